/* src/rdb_key_value_stream_parser_macros.svh */
// Assertion macros for the snapshot parser checker.
// No dependencies; included by the checker file only.
`ifndef RDB_KEY_VALUE_STREAM_PARSER_MACROS_SVH
`define RDB_KEY_VALUE_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RDB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdb checker: implication failed");

// Next-cycle implication, disabled during reset.
`define RDB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdb checker: next-cycle implication failed");

`endif

/* src/rdb_pkg.sv */
// Shared types and constants for the snapshot key/value stream parser.
// No dependencies; used by every module of the block except rdb_fifo.
`default_nettype none

package rdb_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned EXP_W       = 64;
  localparam int unsigned LEN_BITS_DF = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] SEC_MARKER = 8'hFB;
  localparam logic [7:0] EXP_MS     = 8'hFC;
  localparam logic [7:0] EXP_SEC    = 8'hFD;
  localparam logic [7:0] TYPE_STR   = 8'h00;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              is_marker;
    logic              is_exp_ms;
    logic              is_exp_sec;
    logic              is_zero;
  } cls_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              has_exp;
    logic [EXP_W-1:0]  exp_ms;
  } res_t;

endpackage

`default_nettype wire

/* src/rdb_key_value_stream_parser.sv */
// Top level of the snapshot key/value stream parser: front queue, parser, result queue.
// Depends on rdb_pkg, rdb_front, rdb_back and rdb_fifo.
//
//   channel   handshake          payload
//   input     push / full        data_byte_i
//   result    empty / pop        out_kind_o, out_byte_o, last_in_string_o,
//                                has_expiry_o, expire_at_o
//
// One byte per cycle sustained; the parser consumes a queued byte each cycle the
// result queue has room. On idle queues a result enters the result queue as the parser
// accepts its byte, shows on the ports in the cycle after, and can then be popped.
// Seconds expiries are scaled by 1000 in the cycle after their last byte.
// Reset clears both queues and returns the parser to scanning for the section marker.
// Results stall only the parser; bytes keep entering until the input queue fills.
`default_nettype none

module rdb_key_value_stream_parser #(
  parameter int unsigned LENGTH_BITS = rdb_pkg::LEN_BITS_DF,
  parameter int unsigned DEPTH       = rdb_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [rdb_pkg::DATA_W-1:0]  data_byte_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [1:0]                       out_kind_o,
  output logic [rdb_pkg::DATA_W-1:0]       out_byte_o,
  output logic                             last_in_string_o,
  output logic                             has_expiry_o,
  output logic [rdb_pkg::EXP_W-1:0]        expire_at_o
);

  rdb_pkg::cls_t item;
  rdb_pkg::res_t res, res_out;
  logic          item_valid, item_ready, res_valid, res_full;

  rdb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .item_o      (item),
    .valid_o     (item_valid),
    .ready_i     (item_ready)
  );

  rdb_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .valid_i     (item_valid),
    .ready_o     (item_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (!res_full)
  );

  rdb_fifo #(
    .WIDTH ($bits(rdb_pkg::res_t)),
    .DEPTH (DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_kind_o       = res_out.kind;
  assign out_byte_o       = res_out.data;
  assign last_in_string_o = res_out.last;
  assign has_expiry_o     = res_out.has_exp;
  assign expire_at_o      = res_out.exp_ms;

endmodule

`default_nettype wire

/* src/rdb_fifo.sv */
// Small register queue with count-based full/empty flags.
// No package dependency; used by rdb_front and the top level.
`default_nettype none

module rdb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* src/rdb_front.sv */
// Front end: accepts raw file bytes, tags marker/expiry/zero codes, queues them.
// Depends on rdb_pkg and rdb_fifo.
`default_nettype none

module rdb_front #(
  parameter int unsigned DEPTH = rdb_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [rdb_pkg::DATA_W-1:0]  data_byte_i,
  output logic                             full_o,
  output rdb_pkg::cls_t                    item_o,
  output logic                             valid_o,
  input  wire logic                        ready_i
);

  rdb_pkg::cls_t cls;
  logic          empty;

  always_comb begin
    cls.data       = data_byte_i;
    cls.is_marker  = (data_byte_i == rdb_pkg::SEC_MARKER);
    cls.is_exp_ms  = (data_byte_i == rdb_pkg::EXP_MS);
    cls.is_exp_sec = (data_byte_i == rdb_pkg::EXP_SEC);
    cls.is_zero    = (data_byte_i == rdb_pkg::TYPE_STR);
  end

  rdb_fifo #(
    .WIDTH ($bits(rdb_pkg::cls_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (ready_i),
    .data_o  (item_o),
    .empty_o (empty)
  );

  assign valid_o = !empty;

endmodule

`default_nettype wire

/* src/rdb_back.sv */
// Back end: section/entry/string state machine, expiry and length accumulation.
// Depends on rdb_pkg; feeds the result queue in the top level.
`default_nettype none

module rdb_back #(
  parameter int unsigned LENGTH_BITS = rdb_pkg::LEN_BITS_DF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rdb_pkg::cls_t item_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  output logic               res_valid_o,
  output rdb_pkg::res_t      res_o,
  input  wire logic          res_ready_i
);

  localparam logic [3:0] PH_SCAN      = 4'd0;
  localparam logic [3:0] PH_HDR_FIRST = 4'd1;
  localparam logic [3:0] PH_HDR_MORE  = 4'd2;
  localparam logic [3:0] PH_ENTRY     = 4'd3;
  localparam logic [3:0] PH_EXPIRY    = 4'd4;
  localparam logic [3:0] PH_TYPE      = 4'd5;
  localparam logic [3:0] PH_STR_FIRST = 4'd6;
  localparam logic [3:0] PH_STR_MORE  = 4'd7;
  localparam logic [3:0] PH_STR_DATA  = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  localparam int unsigned EW = rdb_pkg::EXP_W;

  logic [3:0]             phase_q, phase_d;
  logic [31:0]            size_q, size_d;
  logic [2:0]             size_cnt_q, size_cnt_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [2:0]             idx_q, idx_d;
  logic [EW-1:0]          exp_q, exp_d;
  logic                   exp_seen_q, exp_seen_d;
  logic                   exp_sec_q, exp_sec_d;
  logic                   scale_q, scale_d;
  logic                   in_val_q, in_val_d;
  logic                   hdr_idx_q, hdr_idx_d;

  logic                   go;
  logic [7:0]             b;
  logic [1:0]             form;
  logic [31:0]            first_val, more_val, len_val;
  logic                   first_done, more_done, len_zero, len_sat;
  logic [LENGTH_BITS-1:0] len_trim;
  logic [EW-1:0]          scaled;
  logic [1:0]             emit_kind;
  logic [7:0]             emit_byte;
  logic                   emit_last;
  logic                   has_exp;

  assign go      = valid_i && res_ready_i;
  assign ready_o = go;
  assign b       = item_i.data;
  assign form    = b[7:6];

  // seconds * 1000 = (x << 10) - (x << 4) - (x << 3)
  assign scaled = (EW'(exp_q[31:0]) << 10) - (EW'(exp_q[31:0]) << 4)
                - (EW'(exp_q[31:0]) << 3);

  assign first_val  = (form == 2'b00 || form == 2'b01) ? {26'd0, b[5:0]} : 32'd0;
  assign first_done = (form == 2'b00 || form == 2'b11);
  assign more_val   = {size_q[23:0], b};
  assign more_done  = (size_cnt_q <= 3'd1);
  assign len_val    = (phase_q == PH_STR_FIRST) ? first_val : more_val;
  assign len_zero   = (len_val == 32'd0);
  assign len_sat    = ((33'(len_val) >> LENGTH_BITS) != 33'd0);
  assign len_trim   = len_sat ? '1 : len_val[LENGTH_BITS-1:0];

  always_comb begin
    phase_d     = phase_q;
    size_d      = size_q;
    size_cnt_d  = size_cnt_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    exp_d       = exp_q;
    exp_seen_d  = exp_seen_q;
    exp_sec_d   = exp_sec_q;
    scale_d     = 1'b0;
    in_val_d    = in_val_q;
    hdr_idx_d   = hdr_idx_q;
    res_valid_o = 1'b0;
    emit_kind   = rdb_pkg::KIND_KEY;
    emit_byte   = 8'd0;
    emit_last   = 1'b0;

    if (scale_q) begin
      exp_d = scaled;
    end

    if (go) begin
      unique case (phase_q)
        PH_SCAN: begin
          if (item_i.is_marker) begin
            hdr_idx_d = 1'b0;
            phase_d   = PH_HDR_FIRST;
          end
        end
        PH_HDR_FIRST, PH_HDR_MORE: begin
          if (phase_q == PH_HDR_FIRST) begin
            size_d     = first_val;
            size_cnt_d = (form == 2'b01) ? 3'd1 : 3'd4;
          end else begin
            size_d     = more_val;
            size_cnt_d = size_cnt_q - 3'd1;
          end
          if ((phase_q == PH_HDR_FIRST) ? first_done : more_done) begin
            if (!hdr_idx_q) begin
              hdr_idx_d = 1'b1;
              phase_d   = PH_HDR_FIRST;
            end else begin
              in_val_d   = 1'b0;
              exp_seen_d = 1'b0;
              exp_sec_d  = 1'b0;
              exp_d      = '0;
              idx_d      = '0;
              phase_d    = PH_ENTRY;
            end
          end else begin
            phase_d = PH_HDR_MORE;
          end
        end
        PH_ENTRY: begin
          if (item_i.is_exp_ms || item_i.is_exp_sec) begin
            exp_seen_d = 1'b0;
            exp_d      = '0;
            idx_d      = '0;
            exp_sec_d  = item_i.is_exp_sec;
            phase_d    = PH_EXPIRY;
          end else if (item_i.is_zero) begin
            in_val_d = 1'b0;
            phase_d  = PH_STR_FIRST;
          end else begin
            exp_seen_d = 1'b0;
            exp_sec_d  = 1'b0;
            exp_d      = '0;
            idx_d      = '0;
          end
        end
        PH_EXPIRY: begin
          exp_d[{idx_q, 3'b000} +: 8] = b;
          if (idx_q >= (exp_sec_q ? 3'd3 : 3'd7)) begin
            exp_seen_d = 1'b1;
            idx_d      = '0;
            scale_d    = exp_sec_q;
            phase_d    = PH_TYPE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_TYPE: begin
          if (item_i.is_zero) begin
            in_val_d = 1'b0;
            phase_d  = PH_STR_FIRST;
          end else begin
            exp_seen_d = 1'b0;
            exp_sec_d  = 1'b0;
            exp_d      = '0;
            idx_d      = '0;
            phase_d    = PH_ENTRY;
          end
        end
        PH_STR_FIRST, PH_STR_MORE: begin
          if (phase_q == PH_STR_FIRST) begin
            size_d     = first_val;
            size_cnt_d = (form == 2'b01) ? 3'd1 : 3'd4;
          end else begin
            size_d     = more_val;
            size_cnt_d = size_cnt_q - 3'd1;
          end
          if ((phase_q == PH_STR_FIRST) ? first_done : more_done) begin
            if (len_zero) begin
              res_valid_o = 1'b1;
              if (!in_val_q) begin
                emit_kind = rdb_pkg::KIND_DONE;
                phase_d   = PH_DONE;
              end else begin
                emit_kind  = rdb_pkg::KIND_EMPTY;
                emit_last  = 1'b1;
                in_val_d   = 1'b0;
                exp_seen_d = 1'b0;
                exp_sec_d  = 1'b0;
                exp_d      = '0;
                idx_d      = '0;
                phase_d    = PH_ENTRY;
              end
            end else begin
              rem_d   = len_trim;
              phase_d = PH_STR_DATA;
            end
          end else begin
            phase_d = PH_STR_MORE;
          end
        end
        PH_STR_DATA: begin
          res_valid_o = 1'b1;
          emit_kind   = in_val_q ? rdb_pkg::KIND_VALUE : rdb_pkg::KIND_KEY;
          emit_byte   = b;
          emit_last   = (rem_q <= LENGTH_BITS'(1));
          rem_d       = rem_q - LENGTH_BITS'(1);
          if (rem_q <= LENGTH_BITS'(1)) begin
            if (!in_val_q) begin
              in_val_d = 1'b1;
              phase_d  = PH_STR_FIRST;
            end else begin
              in_val_d   = 1'b0;
              exp_seen_d = 1'b0;
              exp_sec_d  = 1'b0;
              exp_d      = '0;
              idx_d      = '0;
              phase_d    = PH_ENTRY;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign has_exp       = (emit_kind != rdb_pkg::KIND_DONE) && exp_seen_q;
  assign res_o.kind    = emit_kind;
  assign res_o.data    = emit_byte;
  assign res_o.last    = emit_last;
  assign res_o.has_exp = has_exp;
  assign res_o.exp_ms  = has_exp ? exp_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      size_q     <= '0;
      size_cnt_q <= '0;
      rem_q      <= '0;
      idx_q      <= '0;
      exp_q      <= '0;
      exp_seen_q <= 1'b0;
      exp_sec_q  <= 1'b0;
      scale_q    <= 1'b0;
      in_val_q   <= 1'b0;
      hdr_idx_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      size_q     <= size_d;
      size_cnt_q <= size_cnt_d;
      rem_q      <= rem_d;
      idx_q      <= idx_d;
      exp_q      <= exp_d;
      exp_seen_q <= exp_seen_d;
      exp_sec_q  <= exp_sec_d;
      scale_q    <= scale_d;
      in_val_q   <= in_val_d;
      hdr_idx_q  <= hdr_idx_d;
    end
  end

endmodule

`default_nettype wire

/* src/rdb_checker.sv */
// Port-level checker for the snapshot parser, bound to the top level.
// Depends on rdb_pkg and rdb_key_value_stream_parser_macros.svh.
`default_nettype none
`include "rdb_key_value_stream_parser_macros.svh"

module rdb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        push,
  input wire logic                        full,
  input wire logic [rdb_pkg::DATA_W-1:0]  data_byte_i,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [1:0]                  out_kind_o,
  input wire logic [rdb_pkg::DATA_W-1:0]  out_byte_o,
  input wire logic                        last_in_string_o,
  input wire logic                        has_expiry_o,
  input wire logic [rdb_pkg::EXP_W-1:0]   expire_at_o
);

  `RDB_ASSERT_IMPLY(a_done_clean, clk_i, rst_ni, !empty && out_kind_o == rdb_pkg::KIND_DONE, out_byte_o == '0 && !last_in_string_o && !has_expiry_o && expire_at_o == '0)
  `RDB_ASSERT_IMPLY(a_empty_val, clk_i, rst_ni, !empty && out_kind_o == rdb_pkg::KIND_EMPTY, out_byte_o == '0 && last_in_string_o)
  `RDB_ASSERT_IMPLY(a_no_exp_zero, clk_i, rst_ni, !empty && !has_expiry_o, expire_at_o == '0)
  `RDB_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_kind_o) && $stable(out_byte_o) && $stable(expire_at_o))

endmodule

bind rdb_key_value_stream_parser rdb_checker u_rdb_checker (.*);

`default_nettype wire
